// ----- rtl/core/infix_to_postfix_converter_unit_assert.svh -----
// assertion macros for the infix to postfix converter
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define I2P_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define I2P_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define I2P_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define I2P_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/i2p_pkg.sv -----
// shared constants, types and functions of the infix to postfix converter
`default_nettype none
package i2p_pkg;
    localparam int CHAR_W      = 8;
    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int RANK_W      = 3;

    localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;

    // stack shift control, one per cycle for the whole cell row
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctrl;

    // precedence plus one: '^' 4, '*' '/' 3, '+' '-' 2, all else 0
    function automatic logic [RANK_W-1:0] rank_of(input logic [CHAR_W-1:0] c);
        logic [RANK_W-1:0] r;
        r = '0;
        if (c == CH_CARET) begin
            r = 3'd4;
        end else if (c == CH_STAR || c == CH_SLASH) begin
            r = 3'd3;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            r = 3'd2;
        end
        return r;
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/i2p_ifs.sv -----
// request and result channel interfaces of the infix to postfix converter
`default_nettype none
interface i2p_in_if;
    import i2p_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              end_of_expr;
    modport source (output valid, output in_char, output end_of_expr, input ready);
    modport sink   (input valid, input in_char, input end_of_expr, output ready);
endinterface

interface i2p_out_if;
    import i2p_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              char_valid;
    logic              expr_done;
    logic              run_last;
    logic              overflowed;
    modport source (output valid, output out_char, output char_valid, output expr_done,
                    output run_last, output overflowed, input ready);
    modport sink   (input valid, input out_char, input char_valid, input expr_done,
                    input run_last, input overflowed, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/i2p_cell.sv -----
// one operator stack cell: loads from the cell above on push, from below on pop
`default_nettype none
module i2p_cell (
    input  wire logic                      i_clk,
    input  wire i2p_pkg::t_stk_ctrl        i_ctrl,
    input  wire logic [i2p_pkg::CHAR_W-1:0] i_above,
    input  wire logic [i2p_pkg::CHAR_W-1:0] i_below,
    output logic      [i2p_pkg::CHAR_W-1:0] o_data
);
    import i2p_pkg::*;

    logic [CHAR_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_data <= i_above;
        end else if (i_ctrl.pop) begin
            r_data <= i_below;
        end
    end

    assign o_data = r_data;
endmodule
`default_nettype wire

// ----- rtl/core/i2p_stack.sv -----
// operator stack as a row of shifting cells, top of stack in cell zero
`default_nettype none
module i2p_stack (
    input  wire logic                      i_clk,
    input  wire i2p_pkg::t_stk_ctrl        i_ctrl,
    input  wire logic [i2p_pkg::CHAR_W-1:0] i_push_data,
    output logic      [i2p_pkg::CHAR_W-1:0] o_top,
    output logic      [i2p_pkg::CHAR_W-1:0] o_second
);
    import i2p_pkg::*;

    logic [CHAR_W-1:0] cell_q [STACK_DEPTH];

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            logic [CHAR_W-1:0] above;
            logic [CHAR_W-1:0] below;
            if (g == 0) begin : g_first
                assign above = i_push_data;
            end else begin : g_mid_a
                assign above = cell_q[g-1];
            end
            if (g == STACK_DEPTH - 1) begin : g_last
                assign below = '0;
            end else begin : g_mid_b
                assign below = cell_q[g+1];
            end
            i2p_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (i_ctrl),
                .i_above (above),
                .i_below (below),
                .o_data  (cell_q[g])
            );
        end
    endgenerate

    assign o_top    = cell_q[0];
    assign o_second = cell_q[1];
endmodule
`default_nettype wire

// ----- rtl/core/infix_to_postfix_converter_unit.sv -----
// top level of the shunting-yard infix to postfix converter
//
// takes one expression character per request and sends postfix characters on the
// result channel. letters pass straight out, '(' is stacked, ')' unwinds the stack
// down to the matching '(', other bytes unwind while their precedence is not above
// the top entry and are then stacked. a request with end_of_expr set drains the
// stack and closes with a terminator result (expr_done=1) that carries the sticky
// overflow flag; run_last marks the last result of each request. the operator stack
// is a row of STACK_DEPTH shifting cells with the top in cell zero, so one entry moves
// per cycle unless a pop waits on the result side. a request is accepted in the idle
// state and then acted on in the busy state, which pops the characters it sends to
// the result side one at a time and, for ')', drops the matching '(' in its final
// step. one result leaves per cycle through a single output register; a low ready
// on the result side holds the unit until that register frees up. a push onto a
// full stack is dropped and sets the overflow flag. no clearing pass is needed
// after reset: stack entries above the fill count are never read.
`default_nettype none
module infix_to_postfix_converter_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    i2p_in_if.sink    i_in,
    i2p_out_if.source o_out
);
    import i2p_pkg::*;

    `include "infix_to_postfix_converter_unit_assert.svh"

    // control states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    // request classes, decoded at accept
    localparam logic [2:0] KIND_END    = 3'd0;
    localparam logic [2:0] KIND_LETTER = 3'd1;
    localparam logic [2:0] KIND_LPAREN = 3'd2;
    localparam logic [2:0] KIND_RPAREN = 3'd3;
    localparam logic [2:0] KIND_OTHER  = 3'd4;

    // control state
    logic              r_state, n_state;
    logic [2:0]        r_kind, n_kind;
    logic [CHAR_W-1:0] r_char, n_char;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_lost, n_lost;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_cv;
    logic              r_out_done;
    logic              r_out_last;
    logic              r_out_ovf;

    // result to load this cycle
    logic              emit_en;
    logic [CHAR_W-1:0] emit_char;
    logic              emit_cv;
    logic              emit_done;
    logic              emit_last;
    logic              emit_ovf;

    t_stk_ctrl         stk_ctrl;
    logic [CHAR_W-1:0] stk_top;
    logic [CHAR_W-1:0] stk_second;
    logic              out_free;
    logic              cnt_nz;
    logic              cnt_one;
    logic              cnt_full;
    logic [RANK_W-1:0] top_rank;
    logic [RANK_W-1:0] second_rank;

    i2p_stack u_stack (
        .i_clk       (i_clk),
        .i_ctrl      (stk_ctrl),
        .i_push_data (r_char),
        .o_top       (stk_top),
        .o_second    (stk_second)
    );

    assign out_free    = !r_out_valid || o_out.ready;
    assign cnt_nz      = r_count != '0;
    assign cnt_one     = r_count == CNT_W'(1);
    assign cnt_full    = r_count == CNT_W'(STACK_DEPTH);
    assign top_rank    = rank_of(stk_top);
    assign second_rank = rank_of(stk_second);

    // no request is taken while reset is applied
    assign i_in.ready = i_rst_n && (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_char      = r_char;
        n_rank      = r_rank;
        n_count     = r_count;
        n_lost      = r_lost;
        n_out_valid = r_out_valid && !o_out.ready;
        stk_ctrl    = '0;
        emit_en     = 1'b0;
        emit_char   = stk_top;
        emit_cv     = 1'b1;
        emit_done   = 1'b0;
        emit_last   = 1'b0;
        emit_ovf    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_BUSY;
                    n_char  = i_in.in_char;
                    n_rank  = rank_of(i_in.in_char);
                    if (i_in.end_of_expr) begin
                        n_kind = KIND_END;
                    end else if (is_letter(i_in.in_char)) begin
                        n_kind = KIND_LETTER;
                    end else if (i_in.in_char == CH_LPAREN) begin
                        n_kind = KIND_LPAREN;
                    end else if (i_in.in_char == CH_RPAREN) begin
                        n_kind = KIND_RPAREN;
                    end else begin
                        n_kind = KIND_OTHER;
                    end
                end
            end
            ST_BUSY: begin
                unique case (r_kind)
                    KIND_END: begin
                        if (out_free) begin
                            emit_en = 1'b1;
                            if (cnt_nz) begin
                                // drain one entry, terminator still to come
                                stk_ctrl.pop = 1'b1;
                                n_count      = r_count - CNT_W'(1);
                            end else begin
                                emit_char = '0;
                                emit_cv   = 1'b0;
                                emit_done = 1'b1;
                                emit_last = 1'b1;
                                emit_ovf  = r_lost;
                                n_lost    = 1'b0;
                                n_state   = ST_IDLE;
                            end
                        end
                    end
                    KIND_LETTER: begin
                        if (out_free) begin
                            emit_en   = 1'b1;
                            emit_char = r_char;
                            emit_last = 1'b1;
                            n_state   = ST_IDLE;
                        end
                    end
                    KIND_LPAREN: begin
                        if (cnt_full) begin
                            n_lost = 1'b1;
                        end else begin
                            stk_ctrl.push = 1'b1;
                            n_count       = r_count + CNT_W'(1);
                        end
                        n_state = ST_IDLE;
                    end
                    KIND_RPAREN: begin
                        if (cnt_nz && stk_top != CH_LPAREN) begin
                            if (out_free) begin
                                emit_en      = 1'b1;
                                emit_last    = cnt_one || (stk_second == CH_LPAREN);
                                stk_ctrl.pop = 1'b1;
                                n_count      = r_count - CNT_W'(1);
                            end
                        end else begin
                            // drop the matching '(' if there is one
                            if (cnt_nz) begin
                                stk_ctrl.pop = 1'b1;
                                n_count      = r_count - CNT_W'(1);
                            end
                            n_state = ST_IDLE;
                        end
                    end
                    KIND_OTHER: begin
                        if (cnt_nz && r_rank <= top_rank) begin
                            if (out_free) begin
                                emit_en      = 1'b1;
                                emit_last    = cnt_one || (r_rank > second_rank);
                                stk_ctrl.pop = 1'b1;
                                n_count      = r_count - CNT_W'(1);
                            end
                        end else begin
                            if (cnt_full) begin
                                n_lost = 1'b1;
                            end else begin
                                stk_ctrl.push = 1'b1;
                                n_count       = r_count + CNT_W'(1);
                            end
                            n_state = ST_IDLE;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (emit_en) begin
            n_out_valid = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_lost      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_lost      <= n_lost;
            r_out_valid <= n_out_valid;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_char <= n_char;
        r_rank <= n_rank;
        if (emit_en) begin
            r_out_char <= emit_char;
            r_out_cv   <= emit_cv;
            r_out_done <= emit_done;
            r_out_last <= emit_last;
            r_out_ovf  <= emit_ovf;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_char   = r_out_char;
    assign o_out.char_valid = r_out_cv;
    assign o_out.expr_done  = r_out_done;
    assign o_out.run_last   = r_out_last;
    assign o_out.overflowed = r_out_ovf;

    // fill count never passes the stack depth
    `I2P_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(STACK_DEPTH))
    // a terminator carries no character and closes its request
    `I2P_ASSERT_NOW(a_term_shape, i_clk, i_rst_n, r_out_valid && r_out_done, !r_out_cv && r_out_last)
    // an accepted request is worked on in the next cycle
    `I2P_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in.valid && i_in.ready, r_state == ST_BUSY)
    // after a terminator is loaded the stack is empty and the flag is clear
    `I2P_ASSERT_NEXT(a_term_clean, i_clk, i_rst_n, emit_en && emit_done, r_count == '0 && !r_lost)
endmodule
`default_nettype wire
